// ----- design/lbachs_pkg.sv -----
package lbachs_pkg;

	localparam int LbaW    = 32;
	localparam int CountW  = 7;
	localparam int GeomW   = 8;
	localparam int BytesW  = 13;
	localparam int OffW    = 18;
	localparam int CylW    = 16;
	localparam int StatusW = 3;
	localparam int CfgIdxW = 2;

	localparam logic [StatusW-1:0] ST_CHS    = 3'd0;
	localparam logic [StatusW-1:0] ST_NATIVE = 3'd1;
	localparam logic [StatusW-1:0] ST_EMPTY  = 3'd2;
	localparam logic [StatusW-1:0] ST_SPAN   = 3'd3;
	localparam logic [StatusW-1:0] ST_GEOM   = 3'd4;

	localparam logic [CfgIdxW-1:0] CFG_LBA_NATIVE   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_SECTORS      = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_HEADS        = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_SECTOR_BYTES = 2'd3;

	typedef struct packed {
		logic              command;
		logic [LbaW-1:0]   start_lba;
		logic [CountW-1:0] sector_count;
	} req_t;

	typedef struct packed {
		logic [StatusW-1:0] status;
		logic               direction;
		logic [LbaW-1:0]    current_lba;
		logic [CountW-1:0]  run_count;
		logic [CylW-1:0]    cylinder;
		logic [GeomW-1:0]   head;
		logic [GeomW-1:0]   sector;
		logic [OffW-1:0]    buffer_offset;
		logic               cylinder_wrapped;
		logic               last;
	} res_t;

	typedef struct packed {
		logic load_req;
		logic start_sect;
		logic start_head;
		logic take_geom;
		logic emit_chs;
		logic emit_special;
	} ctrl_cmd_t;

	typedef struct packed {
		logic special;
		logic div_done;
		logic slot_free;
		logic last_sector;
	} dp_stat_t;

endpackage

// ----- design/lbachs_div.sv -----
module lbachs_div
	import lbachs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [LbaW-1:0]  dividend,
	input  logic [GeomW-1:0] divisor,
	output logic             done,
	output logic [LbaW-1:0]  quotient,
	output logic [GeomW-1:0] remainder
);

	localparam int CntW = $clog2(LbaW + 1);

	logic [CntW-1:0]  cnt_q;
	logic             done_q;
	logic [LbaW-1:0]  quo_q;
	logic [GeomW-1:0] rem_q;
	logic [GeomW-1:0] dvs_q;
	logic [GeomW:0]   trial;
	logic             fits;
	logic             busy;

	assign busy  = cnt_q != '0;
	assign trial = {rem_q, quo_q[LbaW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == CntW'(1));
			if (start)
				cnt_q <= CntW'(LbaW);
			else if (busy)
				cnt_q <= cnt_q - CntW'(1);
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[LbaW-2:0], fits};
			rem_q <= fits ? GeomW'(trial - {1'b0, dvs_q}) : trial[GeomW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> cnt_q == CntW'(LbaW))
		else $error("divider did not start");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("divider done without a finished run");

endmodule

// ----- design/lbachs_dp.sv -----
module lbachs_dp
	import lbachs_pkg::*;
#(
	parameter int MAX_RUN = 64
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [BytesW-1:0]  cfg_data,
	input  req_t               req_item,
	output res_t               res_item,
	output logic               res_valid,
	input  logic               res_ready,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat
);

	localparam logic [CountW-1:0] MaxRun = CountW'(MAX_RUN);

	logic              native_q;
	logic [GeomW-1:0]  spt_q;
	logic [GeomW-1:0]  heads_q;
	logic [BytesW-1:0] bytes_q;

	logic               dir_q;
	logic [LbaW-1:0]    lba_q;
	logic [CountW-1:0]  cnt_q;
	logic [CountW-1:0]  left_q;
	logic [StatusW-1:0] code_q;
	logic [GeomW-1:0]   sect_q;
	logic [GeomW-1:0]   head_q;
	logic [LbaW-1:0]    cyl_q;
	logic [OffW-1:0]    off_q;
	logic               res_valid_q;
	res_t               res_q;

	logic [CountW-1:0]  cnt_sat;
	logic [LbaW:0]      span_end;
	logic               span_bad;
	logic [StatusW-1:0] code_in;

	logic             div_start;
	logic [LbaW-1:0]  div_dividend;
	logic [GeomW-1:0] div_divisor;
	logic             div_done;
	logic [LbaW-1:0]  div_quo;
	logic [GeomW-1:0] div_rem;

	logic             sect_wrap;
	logic             head_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_q <= 1'b0;
			spt_q    <= GeomW'(8);
			heads_q  <= GeomW'(2);
			bytes_q  <= BytesW'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LBA_NATIVE:   native_q <= cfg_data[0];
				CFG_SECTORS:      spt_q    <= cfg_data[GeomW-1:0];
				CFG_HEADS:        heads_q  <= cfg_data[GeomW-1:0];
				CFG_SECTOR_BYTES: bytes_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign cnt_sat  = (req_item.sector_count > MaxRun) ? MaxRun : req_item.sector_count;
	assign span_end = {1'b0, req_item.start_lba} + (LbaW+1)'(cnt_sat) - (LbaW+1)'(1);
	assign span_bad = (cnt_sat != '0) && span_end[LbaW];

	always_comb begin
		if (span_bad)
			code_in = ST_SPAN;
		else if (native_q)
			code_in = ST_NATIVE;
		else if (spt_q == '0 || heads_q == '0)
			code_in = ST_GEOM;
		else if (cnt_sat == '0)
			code_in = ST_EMPTY;
		else
			code_in = ST_CHS;
	end

	assign div_start    = cmd.start_sect || cmd.start_head;
	assign div_dividend = cmd.start_sect ? req_item.start_lba : div_quo;
	assign div_divisor  = cmd.start_sect ? spt_q : heads_q;

	lbachs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign sect_wrap = sect_q == spt_q;
	assign head_wrap = ({1'b0, head_q} + (GeomW+1)'(1)) == {1'b0, heads_q};

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			dir_q  <= req_item.command;
			lba_q  <= req_item.start_lba;
			cnt_q  <= cnt_sat;
			left_q <= cnt_sat;
			code_q <= code_in;
			off_q  <= '0;
		end
		if (cmd.start_head)
			sect_q <= div_rem + GeomW'(1);
		if (cmd.take_geom) begin
			head_q <= div_rem;
			cyl_q  <= div_quo;
		end
		if (cmd.emit_chs) begin
			lba_q  <= lba_q + LbaW'(1);
			left_q <= left_q - CountW'(1);
			off_q  <= off_q + OffW'(bytes_q);
			if (sect_wrap) begin
				sect_q <= GeomW'(1);
				if (head_wrap) begin
					head_q <= '0;
					cyl_q  <= cyl_q + LbaW'(1);
				end else begin
					head_q <= head_q + GeomW'(1);
				end
			end else begin
				sect_q <= sect_q + GeomW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_chs) begin
			res_q.status           <= ST_CHS;
			res_q.direction        <= dir_q;
			res_q.current_lba      <= lba_q;
			res_q.run_count        <= '0;
			res_q.cylinder         <= cyl_q[CylW-1:0];
			res_q.head             <= head_q;
			res_q.sector           <= sect_q;
			res_q.buffer_offset    <= off_q;
			res_q.cylinder_wrapped <= |cyl_q[LbaW-1:CylW];
			res_q.last             <= left_q == CountW'(1);
		end else if (cmd.emit_special) begin
			res_q.status           <= code_q;
			res_q.direction        <= dir_q;
			res_q.current_lba      <= lba_q;
			res_q.run_count        <= (code_q == ST_NATIVE) ? cnt_q : '0;
			res_q.cylinder         <= '0;
			res_q.head             <= '0;
			res_q.sector           <= '0;
			res_q.buffer_offset    <= '0;
			res_q.cylinder_wrapped <= 1'b0;
			res_q.last             <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.emit_chs || cmd.emit_special)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	assign res_item         = res_q;
	assign res_valid        = res_valid_q;
	assign stat.special     = code_in != ST_CHS;
	assign stat.div_done    = div_done;
	assign stat.slot_free   = !res_valid_q || res_ready;
	assign stat.last_sector = left_q == CountW'(1);

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_chs || cmd.emit_special) |-> (!res_valid_q || res_ready))
		else $error("result item overwritten before taken");

	a_emit_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_chs |-> left_q != '0)
		else $error("sector emitted past end of run");

endmodule

// ----- design/lbachs_ctrl.sv -----
module lbachs_ctrl
	import lbachs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_SPECIAL  = 5'b00010,
		S_DIV_SECT = 5'b00100,
		S_DIV_HEAD = 5'b01000,
		S_EMIT     = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = state_q == S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					if (stat.special) begin
						state_d = S_SPECIAL;
					end else begin
						cmd.start_sect = 1'b1;
						state_d        = S_DIV_SECT;
					end
				end
			end
			S_SPECIAL: begin
				if (stat.slot_free) begin
					cmd.emit_special = 1'b1;
					state_d          = S_IDLE;
				end
			end
			S_DIV_SECT: begin
				if (stat.div_done) begin
					cmd.start_head = 1'b1;
					state_d        = S_DIV_HEAD;
				end
			end
			S_DIV_HEAD: begin
				if (stat.div_done) begin
					cmd.take_geom = 1'b1;
					state_d       = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.slot_free) begin
					cmd.emit_chs = 1'b1;
					if (stat.last_sector)
						state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q != S_IDLE)
		else $error("item accepted but controller stayed idle");

endmodule

// ----- design/lba_to_chs_sector_run.sv -----
// Converts a block request (direction, start LBA, sector count) into one
// cylinder/head/sector address per sector, with the buffer offset of each,
// or forwards it whole in LBA-native mode. Rejected, empty and forwarded
// requests give a single result, written to the output register once the
// output slot is free. A converted request runs two divisions on one
// shared bit-serial divider (LBA by sectors per track, then track by
// heads), and then emits one sector address per cycle while the consumer
// keeps up. A new item is taken once the last result of the previous one
// sits in the output register.
module lba_to_chs_sector_run
	import lbachs_pkg::*;
#(
	parameter int MAX_RUN = 64
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [BytesW-1:0]  cfg_data,
	input  logic               req_valid,
	output logic               req_ready,
	input  req_t               req_item,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res_item
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	lbachs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lbachs_dp #(
		.MAX_RUN (MAX_RUN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_item  (req_item),
		.res_item  (res_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
